// File: rtl/hqt_pkg.sv
// ----------------------------------------------------------------------------
// hqt_pkg
// Types and constants shared by the host quarantine table modules.
// ----------------------------------------------------------------------------
package hqt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 32;
  localparam int DUR_W       = 32;
  localparam int TIME_W      = 48;

  localparam logic REQ_QUARANTINE = 1'b0;
  localparam logic REQ_QUERY      = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] host_addr;
    logic [DUR_W-1:0]  hold_ms;
    logic [TIME_W-1:0] now_ms;
  } hqt_req_t;

  typedef struct packed {
    logic stored_ok;
    logic is_blocked;
  } hqt_result_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] host;
    logic [TIME_W-1:0] expiry;
  } hqt_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd_en;
    logic cnt_inc;
    logic commit;
  } hqt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
  } hqt_sts_t;

endpackage

// File: rtl/hqt_ctrl.sv
// ----------------------------------------------------------------------------
// hqt_ctrl
// Sequencer for the clearing pass and the per-request table scan.
// ----------------------------------------------------------------------------
module hqt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  hqt_pkg::hqt_sts_t sts,
  output hqt_pkg::hqt_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      // The read of the last slot is evaluated in this cycle.
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/hqt_datapath.sv
// ----------------------------------------------------------------------------
// hqt_datapath
// Slot memory, scan counter, match and free-slot trackers, and result logic.
// ----------------------------------------------------------------------------
module hqt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  hqt_pkg::hqt_req_t    req,
  input  hqt_pkg::hqt_cmd_t    cmd,
  output hqt_pkg::hqt_sts_t    sts,
  output logic                 done,
  output hqt_pkg::hqt_result_t result
);

  localparam int IDX_W  = hqt_pkg::IDX_W;
  localparam int TIME_W = hqt_pkg::TIME_W;

  hqt_pkg::hqt_entry_t mem [hqt_pkg::TABLE_DEPTH];

  logic [IDX_W-1:0]    cnt;
  hqt_pkg::hqt_req_t   cur;
  logic [TIME_W-1:0]   new_expiry;
  hqt_pkg::hqt_entry_t rd_data;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_vld;

  logic                hit_found;
  logic [IDX_W-1:0]    hit_idx;
  logic [TIME_W-1:0]   hit_expiry;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  logic [TIME_W:0]     sum;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  hqt_pkg::hqt_entry_t wr_data;
  hqt_pkg::hqt_result_t result_next;

  assign sts.cnt_last = (cnt == IDX_W'(hqt_pkg::TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= sts.cnt_last ? '0 : cnt + 1'b1;
    end
  end

  // Expiry saturates at the top of the time range.
  assign sum = {1'b0, req.now_ms} + {{(TIME_W + 1 - hqt_pkg::DUR_W){1'b0}}, req.hold_ms};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur        <= req;
      new_expiry <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[cnt];
      rd_idx  <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  // Host addresses are unique among valid slots, so the first hit is the only one.
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (rd_data.valid && (rd_data.host == cur.host_addr) && !hit_found) begin
        hit_found <= 1'b1;
      end
      if (!rd_data.valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && rd_data.valid && (rd_data.host == cur.host_addr) && !hit_found) begin
      hit_idx    <= rd_idx;
      hit_expiry <= rd_data.expiry;
    end
    if (rd_vld && !rd_data.valid && !free_found) begin
      free_idx <= rd_idx;
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = cnt;
    wr_data     = '0;
    result_next = '0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.commit) begin
      if (cur.req_type == hqt_pkg::REQ_QUARANTINE) begin
        wr_data.valid  = 1'b1;
        wr_data.host   = cur.host_addr;
        wr_data.expiry = new_expiry;
        if (hit_found) begin
          wr_en                 = 1'b1;
          wr_addr               = hit_idx;
          result_next.stored_ok = 1'b1;
        end else if (free_found) begin
          wr_en                 = 1'b1;
          wr_addr               = free_idx;
          result_next.stored_ok = 1'b1;
        end
      end else if (hit_found) begin
        if (cur.now_ms < hit_expiry) begin
          result_next.is_blocked = 1'b1;
        end else begin
          // An expired entry is released by the query that finds it.
          wr_en          = 1'b1;
          wr_addr        = hit_idx;
          wr_data.valid  = 1'b0;
          wr_data.host   = cur.host_addr;
          wr_data.expiry = hit_expiry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.stored_ok && result.is_blocked))
    else $error("stored and blocked reported together");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !wr_en)
    else $error("table written during a scan");
  a_query_never_stores: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cur.req_type == hqt_pkg::REQ_QUERY) |=> !result.stored_ok)
    else $error("query reported as stored");
`endif

endmodule

// File: rtl/host_quarantine_table_unit.sv
// Each request is served by a full scan: the controller goes from IDLE through SCAN, DRAIN and DECIDE,
// and every slot is read once through the single memory read port; done and result are registered.
// Requests are handled one at a time, not overlapped; start is taken again in the result cycle.
// Reset: a clearing pass marks every slot free, with busy held high.
// The done strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// host_quarantine_table_unit
// Table of quarantined IPv4 hosts with saturating expiry times.
// ----------------------------------------------------------------------------
module host_quarantine_table_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  hqt_pkg::hqt_req_t    req,
  output logic                 done,
  output hqt_pkg::hqt_result_t result
);

  hqt_pkg::hqt_cmd_t cmd;
  hqt_pkg::hqt_sts_t sts;

  hqt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hqt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .done   (done),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");
`endif

endmodule

// File: bench/host_quarantine_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_quarantine_table_unit_test
// Self-checking bench for the host quarantine table. Requests are driven
// through the start/busy handshake and each done strobe is compared with a
// verdict worked out from a shadow copy of the table. Directed cases come
// first, then a random mix over a small host pool, then the table is filled.
// ----------------------------------------------------------------------------
module host_quarantine_table_unit_test;

  localparam int TABLE_DEPTH  = hqt_pkg::TABLE_DEPTH;
  localparam int ADDR_W       = hqt_pkg::ADDR_W;
  localparam int DUR_W        = hqt_pkg::DUR_W;
  localparam int TIME_W       = hqt_pkg::TIME_W;
  localparam int HOLD_CYCLES  = TABLE_DEPTH + 8;
  localparam int RANDOM_ITEMS = 180;
  localparam int HOST_POOL    = 24;
  localparam int ITEM_BUDGET  = 1500;
  localparam longint CYCLE_LIMIT =
    64'(ITEM_BUDGET) * (TABLE_DEPTH + 16) * 3 + TABLE_DEPTH * 4;
  localparam logic [TIME_W-1:0] TIME_END = '1;
  localparam logic [DUR_W-1:0]  DUR_END  = '1;
  localparam int PRINT_CAP = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  hqt_pkg::hqt_req_t    req;
  logic                 done;
  hqt_pkg::hqt_result_t result;

  // Shadow copy of the table.
  logic              tbl_valid  [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_host   [TABLE_DEPTH];
  logic [TIME_W-1:0] tbl_expiry [TABLE_DEPTH];

  hqt_pkg::hqt_result_t pending_verdicts[$];
  hqt_pkg::hqt_result_t oldest_verdict;
  int                errors;
  int                n_sent, n_quarantine, n_query, n_stored, n_refused, n_blocked;
  int                n_checked;
  longint            cycle_count = 0;
  bit                idle_on;
  logic [TIME_W-1:0] clock_ms;

  host_quarantine_table_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_verdicts.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int find_slot(input logic [ADDR_W-1:0] host);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_host[i] == host) return i;
    end
    return -1;
  endfunction

  function automatic int occupied();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i]) n++;
    end
    return n;
  endfunction

  // Applies one request to the shadow table and returns its verdict.
  function automatic hqt_pkg::hqt_result_t quarantine_verdict(input hqt_pkg::hqt_req_t r);
    hqt_pkg::hqt_result_t v;
    logic [TIME_W:0]      sum;
    int                   slot;
    v = '0;
    slot = find_slot(r.host_addr);
    if (r.req_type == hqt_pkg::REQ_QUARANTINE) begin
      sum = {1'b0, r.now_ms} + (TIME_W + 1)'(r.hold_ms);
      if (slot < 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!tbl_valid[i]) begin
            slot = i;
            break;
          end
        end
      end
      if (slot >= 0) begin
        tbl_valid[slot]  = 1'b1;
        tbl_host[slot]   = r.host_addr;
        tbl_expiry[slot] = sum[TIME_W] ? TIME_END : sum[TIME_W-1:0];
        v.stored_ok      = 1'b1;
      end
    end else if (slot >= 0) begin
      if (r.now_ms < tbl_expiry[slot]) v.is_blocked = 1'b1;
      else tbl_valid[slot] = 1'b0;
    end
    return v;
  endfunction

  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] host,
                              input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
    hqt_pkg::hqt_req_t    r;
    hqt_pkg::hqt_result_t v;
    r = '{req_type: kind, host_addr: host, hold_ms: dur, now_ms: now};
    // An idle gap only shows once the block is ready again, so wait for that first.
    if (idle_on && $urandom_range(0, 99) < 15) begin
      while (busy !== 1'b0) @(posedge clk);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    v = quarantine_verdict(r);
    pending_verdicts.push_back(v);
    n_sent++;
    if (kind == hqt_pkg::REQ_QUARANTINE) begin
      n_quarantine++;
      if (v.stored_ok) n_stored++;
      else n_refused++;
    end else begin
      n_query++;
      if (v.is_blocked) n_blocked++;
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        n_checked++;
        if (result.stored_ok !== oldest_verdict.stored_ok)
          report_mismatch($sformatf("stored_ok is %b, expected %b",
                                    result.stored_ok, oldest_verdict.stored_ok));
        if (result.is_blocked !== oldest_verdict.is_blocked)
          report_mismatch($sformatf("is_blocked is %b, expected %b",
                                    result.is_blocked, oldest_verdict.is_blocked));
      end
    end
  end

  task automatic test_unknown_host();
    send_request(hqt_pkg::REQ_QUERY, '0, '0, '0);
    send_request(hqt_pkg::REQ_QUERY, '1, DUR_END, TIME_END);
  endtask

  task automatic test_block_and_expire();
    send_request(hqt_pkg::REQ_QUARANTINE, 32'hC0A8_0001, 32'd100, 48'd1000);
    send_request(hqt_pkg::REQ_QUERY, 32'hC0A8_0001, '0, 48'd1050);
    send_request(hqt_pkg::REQ_QUERY, 32'hC0A8_0001, '0, 48'd1099);
    // The query at the expiry time itself frees the slot.
    send_request(hqt_pkg::REQ_QUERY, 32'hC0A8_0001, '0, 48'd1100);
    send_request(hqt_pkg::REQ_QUERY, 32'hC0A8_0001, '0, 48'd1050);
  endtask

  task automatic test_overwrite();
    send_request(hqt_pkg::REQ_QUARANTINE, 32'h0A00_0002, 32'd10, '0);
    send_request(hqt_pkg::REQ_QUARANTINE, 32'h0A00_0002, 32'd1000, '0);
    send_request(hqt_pkg::REQ_QUERY, 32'h0A00_0002, '0, 48'd500);
    send_request(hqt_pkg::REQ_QUARANTINE, 32'h0A00_0002, 32'd5, '0);
    send_request(hqt_pkg::REQ_QUERY, 32'h0A00_0002, '0, 48'd500);
  endtask

  task automatic test_zero_duration();
    send_request(hqt_pkg::REQ_QUARANTINE, 32'h0A00_0003, '0, 48'd5000);
    send_request(hqt_pkg::REQ_QUERY, 32'h0A00_0003, '0, 48'd4999);
    send_request(hqt_pkg::REQ_QUERY, 32'h0A00_0003, '0, 48'd5000);
    send_request(hqt_pkg::REQ_QUERY, 32'h0A00_0003, '0, 48'd4999);
  endtask

  task automatic test_time_saturation();
    send_request(hqt_pkg::REQ_QUARANTINE, '0, DUR_END, TIME_END - 48'd5);
    send_request(hqt_pkg::REQ_QUERY, '0, '0, TIME_END - 48'd1);
    send_request(hqt_pkg::REQ_QUARANTINE, '1, DUR_END, TIME_END);
    send_request(hqt_pkg::REQ_QUERY, '1, '0, TIME_END);
    send_request(hqt_pkg::REQ_QUERY, '0, '0, TIME_END);
  endtask

  task automatic test_random_mix();
    logic [ADDR_W-1:0] pool[HOST_POOL];
    logic [ADDR_W-1:0] host;
    logic [DUR_W-1:0]  dur;
    logic [63:0]       wide;
    logic              kind;
    foreach (pool[i]) pool[i] = $urandom();
    clock_ms = TIME_W'($urandom_range(0, 1000));
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // The middle third runs without any idle gaps.
      idle_on = !(k >= RANDOM_ITEMS / 3 && k < 2 * RANDOM_ITEMS / 3);
      kind = $urandom_range(0, 1) ? hqt_pkg::REQ_QUERY : hqt_pkg::REQ_QUARANTINE;
      host = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, HOST_POOL - 1)]
                                          : $urandom();
      if ($urandom_range(0, 99) < 4) begin
        wide = {$urandom(), $urandom()};
        clock_ms = wide[TIME_W-1:0];
      end else begin
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 60));
      end
      case ($urandom_range(0, 9))
        0: dur = '0;
        1: dur = $urandom();
        2: dur = $urandom_range(0, 5000);
        default: dur = $urandom_range(1, 150);
      endcase
      send_request(kind, host, dur, clock_ms);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_full_table();
    logic [ADDR_W-1:0] short_hosts[$];
    logic [ADDR_W-1:0] host;
    logic [ADDR_W-1:0] last_long;
    int                k;
    k = 0;
    last_long = '0;
    clock_ms = 48'h0010_0000_0000;
    while (occupied() < TABLE_DEPTH) begin
      host = 32'h5A00_0000 + 32'(k);
      k++;
      if (find_slot(host) < 0) begin
        // A few entries expire at once; they must still hold their slots.
        if (short_hosts.size() < 3) begin
          short_hosts.push_back(host);
          send_request(hqt_pkg::REQ_QUARANTINE, host, 32'd1, clock_ms);
        end else begin
          last_long = host;
          send_request(hqt_pkg::REQ_QUARANTINE, host,
                       32'h0100_0000 + $urandom_range(0, 1000), clock_ms);
        end
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 2));
      end
    end
    clock_ms = clock_ms + 48'd100;
    host = 32'h5A00_0000 + 32'(k);
    send_request(hqt_pkg::REQ_QUARANTINE, host, 32'd50, clock_ms);
    send_request(hqt_pkg::REQ_QUERY, host, '0, clock_ms);
    send_request(hqt_pkg::REQ_QUARANTINE, last_long, 32'd77, clock_ms);
    send_request(hqt_pkg::REQ_QUERY, last_long, '0, clock_ms + 48'd10);
    send_request(hqt_pkg::REQ_QUERY, short_hosts[0], '0, clock_ms);
    send_request(hqt_pkg::REQ_QUARANTINE, host, 32'd50, clock_ms);
    send_request(hqt_pkg::REQ_QUARANTINE, host + 32'd1, 32'd50, clock_ms);
    send_request(hqt_pkg::REQ_QUERY, short_hosts[1], '0, clock_ms);
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    errors       = 0;
    n_sent       = 0;
    n_quarantine = 0;
    n_query      = 0;
    n_stored     = 0;
    n_refused    = 0;
    n_blocked    = 0;
    n_checked    = 0;
    idle_on      = 1'b1;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_unknown_host();
    drain_results();
    test_block_and_expire();
    test_overwrite();
    drain_results();
    test_zero_duration();
    test_time_saturation();
    drain_results();
    test_random_mix();
    drain_results();
    test_full_table();
    drain_results();
    repeat (HOLD_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d quarantines (%0d stored, %0d refused), %0d queries.",
             n_sent, n_quarantine, n_stored, n_refused, n_query);
    $display("Checked %0d results, %0d blocked, with the table filled to all %0d slots.",
             n_checked, n_blocked, TABLE_DEPTH);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
